>>> sv/i2cmts_pkg.sv
// i2cmts_pkg: request codes, status codes and field types of the I2C
// master transfer sequencer
// no dependencies
package i2cmts_pkg;

   // request command codes
   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_START = 2'd0;
   localparam cmd_type CMD_LOAD  = 2'd1;
   localparam cmd_type CMD_EVENT = 2'd2;

   // result status codes
   typedef logic [1:0] status_type;
   localparam status_type STATUS_BUSY       = 2'd0;
   localparam status_type STATUS_OK         = 2'd1;
   localparam status_type STATUS_INCOMPLETE = 2'd2;
   localparam status_type STATUS_REJECTED   = 2'd3;

   // field types
   typedef logic [7:0] byte_type;
   typedef logic [9:0] addr_type;
   typedef logic [4:0] wcount_type;

   // 10-bit addressing header prefix and mask of the upper address bits
   localparam logic [6:0] TEN_BIT_PREFIX = 7'h78;
   localparam logic [1:0] TEN_BIT_HI_MASK = 2'h3;

   // starts counter saturation point
   localparam logic [1:0] STARTS_SAT = 2'd2;

endpackage

>>> sv/i2c_master_transfer_sequencer.sv
// i2c_master_transfer_sequencer: sequencer for one I2C master write-then-read
// transfer on top of a byte-level engine, with its transmit byte buffer
// depends on i2cmts_pkg
//
// Takes one request per clock and returns exactly one result for it, in the cycle
// after acceptance, held in an output register until taken; a new request is
// accepted whenever that register is empty or being taken in the same cycle.
// A start request sets up 7-bit or 10-bit addressing and the byte counts and
// writes the first address byte (both counts zero is rejected with status 3);
// load requests append bytes to a TX_DEPTH entry transmit buffer; event
// requests carry the engine flags and are handled as the engine interrupt
// service would, choosing the byte to write or the read to do and updating
// the control bits. The transmit buffer is a RAM with a registered read port
// that is kept one step ahead on the next send position, with bypass of a
// load to that same position, so the next byte to send is already registered.
// Sending a buffer entry never loaded gives an undefined byte.
module i2c_master_transfer_sequencer #(
   parameter int TX_DEPTH = 16,
   parameter int READ_MAX = 255
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  i2cmts_pkg::cmd_type     req_command,
   input  logic                    req_ten_bit,
   input  i2cmts_pkg::addr_type    req_target_address,
   input  i2cmts_pkg::wcount_type  req_write_count,
   input  i2cmts_pkg::byte_type    req_read_count,
   input  i2cmts_pkg::byte_type    req_tx_byte,
   input  logic                    req_stop_flag,
   input  logic                    req_start_flag,
   input  logic                    req_nack_flag,
   input  logic                    req_byte_complete,
   input  i2cmts_pkg::byte_type    req_rx_byte,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_write_valid,
   output i2cmts_pkg::byte_type    rsp_write_byte,
   output logic                    rsp_read_strobe,
   output logic                    rsp_rx_valid,
   output i2cmts_pkg::byte_type    rsp_rx_data,
   output logic                    rsp_master_bit,
   output logic                    rsp_transmit_bit,
   output logic                    rsp_no_ack_bit,
   output logic                    rsp_repeat_start,
   output logic                    rsp_irq_enable,
   output logic                    rsp_done_res,
   output i2cmts_pkg::status_type  rsp_status
);
   import i2cmts_pkg::*;

   localparam int CW = $clog2(TX_DEPTH + 1);
   localparam int IW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int RW = $clog2(READ_MAX + 1);

   typedef enum logic [1:0] {
      HALT_RUN,
      HALT_STOPPED,
      HALT_NACK
   } halt_type;

   // handshake
   logic accept;

   // transfer state
   logic [CW-1:0] load_index_ff, load_index_in;
   logic [CW-1:0] send_index_ff, send_index_in;
   logic [CW-1:0] writes_left_ff, writes_left_in;
   logic [RW-1:0] reads_left_ff, reads_left_in;
   logic          second_addr_ff, second_addr_in;
   logic          readdress_ff, readdress_in;
   logic          turnaround_ff, turnaround_in;
   logic [6:0]    addr_first_ff, addr_first_in;
   byte_type      addr_second_ff, addr_second_in;
   halt_type      halt_ff, halt_in;
   logic [1:0]    starts_ff, starts_in;
   logic          master_ff, master_in;
   logic          transmit_ff, transmit_in;
   logic          no_ack_ff, no_ack_in;
   logic          irq_ff, irq_in;

   // result registers
   logic          rsp_valid_ff, rsp_valid_in;
   logic          wv_ff, wv_in;
   byte_type      wb_ff, wb_in;
   logic          rs_ff, rs_in;
   logic          rv_ff, rv_in;
   byte_type      rd_ff, rd_in;
   logic          rep_ff, rep_in;
   logic          done_ff, done_in;
   status_type    status_ff, status_in;

   // start decode helpers
   logic [31:0]   wc_ext;
   logic [31:0]   rc_ext;
   logic [31:0]   load_ext;
   logic [CW-1:0] wc_sat;
   logic [RW-1:0] rc_sat;
   logic          first_start;

   // transmit buffer
   byte_type      tx_buffer_ff [TX_DEPTH];
   byte_type      tx_rdata_ff;
   logic          tx_we;
   logic [IW-1:0] tx_waddr;
   logic [IW-1:0] tx_raddr;

   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   // saturate the requested counts
   assign wc_ext   = {27'd0, req_write_count};
   assign rc_ext   = {24'd0, req_read_count};
   assign load_ext = 32'(load_index_ff);
   assign wc_sat   = (wc_ext > 32'(TX_DEPTH)) ? CW'(TX_DEPTH) : CW'(wc_ext);
   assign rc_sat   = (rc_ext > 32'(READ_MAX)) ? RW'(READ_MAX) : RW'(rc_ext);

   // buffer ports: write at the load position, read ahead at the next send position
   assign tx_we    = accept && (req_command == CMD_LOAD) && (load_ext < 32'(TX_DEPTH));
   assign tx_waddr = load_index_ff[IW-1:0];
   assign tx_raddr = send_index_in[IW-1:0];

   // request decode and next state
   always_comb begin
      load_index_in  = load_index_ff;
      send_index_in  = send_index_ff;
      writes_left_in = writes_left_ff;
      reads_left_in  = reads_left_ff;
      second_addr_in = second_addr_ff;
      readdress_in   = readdress_ff;
      turnaround_in  = turnaround_ff;
      addr_first_in  = addr_first_ff;
      addr_second_in = addr_second_ff;
      halt_in        = halt_ff;
      starts_in      = starts_ff;
      master_in      = master_ff;
      transmit_in    = transmit_ff;
      no_ack_in      = no_ack_ff;
      irq_in         = irq_ff;
      wv_in          = 1'b0;
      wb_in          = '0;
      rs_in          = 1'b0;
      rv_in          = 1'b0;
      rd_in          = '0;
      rep_in         = 1'b0;
      done_in        = 1'b0;
      status_in      = STATUS_BUSY;
      first_start    = 1'b0;

      if (accept) begin
         unique case (req_command)
            CMD_START: begin
               if ((req_write_count == '0) && (req_read_count == '0)) begin
                  done_in   = 1'b1;
                  status_in = STATUS_REJECTED;
               end else begin
                  writes_left_in = wc_sat;
                  reads_left_in  = rc_sat;
                  send_index_in  = '0;
                  load_index_in  = '0;
                  halt_in        = HALT_RUN;
                  turnaround_in  = (req_read_count != '0);
                  if (req_ten_bit) begin
                     second_addr_in = 1'b1;
                     readdress_in   = 1'b0;
                     addr_second_in = req_target_address[7:0];
                     addr_first_in  = TEN_BIT_PREFIX |
                                      {5'd0, req_target_address[9:8] & TEN_BIT_HI_MASK};
                     wb_in          = {addr_first_in, 1'b0};
                  end else begin
                     second_addr_in = 1'b0;
                     readdress_in   = (req_write_count != '0) && (req_read_count != '0);
                     addr_second_in = '0;
                     addr_first_in  = req_target_address[6:0];
                     wb_in          = {addr_first_in, (req_write_count == '0)};
                  end
                  wv_in       = 1'b1;
                  transmit_in = 1'b1;
                  irq_in      = 1'b1;
                  master_in   = 1'b1;
               end
            end
            CMD_LOAD: begin
               if (tx_we) begin
                  load_index_in = load_index_ff + CW'(1);
               end
            end
            CMD_EVENT: begin
               // stop ends the transfer and reports the outcome
               if (req_stop_flag) begin
                  starts_in = '0;
                  halt_in   = HALT_STOPPED;
                  irq_in    = 1'b0;
                  done_in   = 1'b1;
                  status_in = ((writes_left_ff != '0) || (reads_left_ff != '0)) ?
                              STATUS_INCOMPLETE : STATUS_OK;
               end
               // the first start of a transfer is only counted
               if (req_start_flag) begin
                  if (starts_in < STARTS_SAT) begin
                     starts_in = starts_in + 2'd1;
                  end
                  first_start = (starts_in <= 2'd1);
               end
               if (!first_start && (halt_in == HALT_RUN)) begin
                  // missing ack while transmitting halts the transfer
                  if (transmit_ff && req_nack_flag && req_byte_complete) begin
                     master_in   = 1'b0;
                     transmit_in = 1'b0;
                     halt_in     = HALT_NACK;
                  end
                  if (halt_in == HALT_RUN) begin
                     if (second_addr_ff) begin
                        second_addr_in = 1'b0;
                        if (reads_left_ff != '0) begin
                           readdress_in = 1'b1;
                        end
                        wv_in = 1'b1;
                        wb_in = addr_second_ff;
                        if ((writes_left_ff == '0) && (reads_left_ff != '0)) begin
                           rep_in    = 1'b1;
                           no_ack_in = 1'b1;
                        end
                     end else if (writes_left_ff != '0) begin
                        wv_in          = 1'b1;
                        wb_in          = tx_rdata_ff;
                        send_index_in  = send_index_ff + CW'(1);
                        writes_left_in = writes_left_ff - CW'(1);
                        if ((writes_left_in == '0) && (reads_left_ff != '0)) begin
                           rep_in    = 1'b1;
                           no_ack_in = 1'b1;
                        end
                     end else if (readdress_ff) begin
                        readdress_in = 1'b0;
                        wv_in        = 1'b1;
                        wb_in        = {addr_first_ff, 1'b1};
                     end else if (turnaround_ff) begin
                        // dummy read switches the engine to receive
                        turnaround_in = 1'b0;
                        transmit_in   = 1'b0;
                        rs_in         = 1'b1;
                        no_ack_in     = (reads_left_ff == RW'(1));
                     end else if (reads_left_ff != '0) begin
                        reads_left_in = reads_left_ff - RW'(1);
                        if (reads_left_in == '0) begin
                           transmit_in = 1'b1;
                           master_in   = 1'b0;
                        end
                        rs_in = 1'b1;
                        rv_in = 1'b1;
                        rd_in = req_rx_byte;
                        if (reads_left_in == RW'(1)) begin
                           no_ack_in = 1'b1;
                        end
                     end else begin
                        transmit_in = 1'b1;
                        master_in   = 1'b0;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         load_index_ff  <= '0;
         send_index_ff  <= '0;
         writes_left_ff <= '0;
         reads_left_ff  <= '0;
         second_addr_ff <= 1'b0;
         readdress_ff   <= 1'b0;
         turnaround_ff  <= 1'b0;
         addr_first_ff  <= '0;
         addr_second_ff <= '0;
         halt_ff        <= HALT_RUN;
         starts_ff      <= '0;
         master_ff      <= 1'b0;
         transmit_ff    <= 1'b0;
         no_ack_ff      <= 1'b0;
         irq_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         load_index_ff  <= load_index_in;
         send_index_ff  <= send_index_in;
         writes_left_ff <= writes_left_in;
         reads_left_ff  <= reads_left_in;
         second_addr_ff <= second_addr_in;
         readdress_ff   <= readdress_in;
         turnaround_ff  <= turnaround_in;
         addr_first_ff  <= addr_first_in;
         addr_second_ff <= addr_second_in;
         halt_ff        <= halt_in;
         starts_ff      <= starts_in;
         master_ff      <= master_in;
         transmit_ff    <= transmit_in;
         no_ack_ff      <= no_ack_in;
         irq_ff         <= irq_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      if (accept) begin
         wv_ff     <= wv_in;
         wb_ff     <= wb_in;
         rs_ff     <= rs_in;
         rv_ff     <= rv_in;
         rd_ff     <= rd_in;
         rep_ff    <= rep_in;
         done_ff   <= done_in;
         status_ff <= status_in;
      end
   end

   // transmit buffer with read-ahead and load bypass
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_buffer_ff[tx_waddr] <= req_tx_byte;
      end
      if (tx_we && (tx_waddr == tx_raddr)) begin
         tx_rdata_ff <= req_tx_byte;
      end else begin
         tx_rdata_ff <= tx_buffer_ff[tx_raddr];
      end
   end

   // result outputs; control bits move only with an accepted request
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_valid  = wv_ff;
   assign rsp_write_byte   = wb_ff;
   assign rsp_read_strobe  = rs_ff;
   assign rsp_rx_valid     = rv_ff;
   assign rsp_rx_data      = rd_ff;
   assign rsp_master_bit   = master_ff;
   assign rsp_transmit_bit = transmit_ff;
   assign rsp_no_ack_bit   = no_ack_ff;
   assign rsp_repeat_start = rep_ff;
   assign rsp_irq_enable   = irq_ff;
   assign rsp_done_res     = done_ff;
   assign rsp_status       = status_ff;

   // a result never writes and reads the engine data register together
   a_write_read_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(wv_ff && rs_ff))
      else $error("write and read strobe in one result");

   // a delivered byte always comes with a data register read
   a_rx_needs_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rv_ff) |-> rs_ff)
      else $error("received byte without read strobe");

   // status is only reported with done
   a_status_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !done_ff) |-> (status_ff == STATUS_BUSY))
      else $error("status set without done");

   // an accepted load into a non-full buffer advances the load position
   a_load_advance: assert property (@(posedge clock) disable iff (reset)
      tx_we |=> (load_index_ff == $past(load_index_ff) + CW'(1)))
      else $error("load position did not advance");

   // send position never runs past the buffer
   a_send_bound: assert property (@(posedge clock) disable iff (reset)
      32'(send_index_ff) <= 32'(TX_DEPTH))
      else $error("send position beyond buffer");

endmodule
